/* rtl/wtdf_pkg.sv */
// ----------------------------------------------------------------------------
// wtdf_pkg
// Shared types and character-class helpers for the word tokenizer with
// decorator filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wtdf_pkg;

  localparam int unsigned CharW     = 16;
  localparam int unsigned MaxResult = 4;
  localparam int unsigned CntW      = $clog2(MaxResult + 1);
  localparam int unsigned IdxW      = $clog2(MaxResult);

  // Pending run length codes
  localparam logic [1:0] RunNone = 2'd0;
  localparam logic [1:0] RunOne  = 2'd1;
  localparam logic [1:0] RunTwo  = 2'd2;
  localparam logic [1:0] RunLong = 2'd3;

  // Result kinds
  localparam logic KindChar    = 1'b0;
  localparam logic KindWordEnd = 1'b1;

  // All results caused by one accepted character
  typedef struct packed {
    logic [CntW-1:0]                 cnt;
    logic [MaxResult-1:0]            kind;
    logic [MaxResult-1:0][CharW-1:0] chr;
  } burst_t;

  function automatic logic is_space(input logic [CharW-1:0] c);
    is_space = (c == 16'h0020) || ((c >= 16'h0009) && (c <= 16'h000D));
  endfunction

  function automatic logic is_decorator(input logic [CharW-1:0] c);
    is_decorator = (c == 16'h002D) || (c == 16'h002B) || (c == 16'h005F) ||
                   (c == 16'h003D) || (c == 16'h007C) || (c == 16'h007E);
  endfunction

endpackage

`default_nettype wire

/* rtl/wtdf_step.sv */
// ----------------------------------------------------------------------------
// wtdf_step
// Word/run state and the single-pass decision logic that turns one character
// into its list of results.
// ----------------------------------------------------------------------------
`default_nettype none

module wtdf_step import wtdf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [CharW-1:0] ch,
  input  wire logic             end_of_text,
  output burst_t                burst
);

  logic [CharW-1:0] run_char, run_char_next;
  logic [1:0]       run_length, run_length_next;
  logic             word_emitted, word_emitted_next;

  logic             sp, ext, dec, close;
  logic [1:0]       a_cnt, c_cnt;
  logic             b_put, d_put;
  logic [1:0]       mid_len;
  logic [CharW-1:0] mid_char;
  logic             mid_we;
  logic [2:0]       ab, abc;

  always_comb begin
    sp    = is_space(ch);
    dec   = is_decorator(ch);
    ext   = !sp && (run_length != RunNone) && (ch == run_char);
    a_cnt = 2'd0;
    b_put = 1'b0;
    mid_len  = run_length;
    mid_char = run_char;
    mid_we   = word_emitted;
    if (!sp) begin
      if (ext) begin
        if (run_length != RunLong) begin
          mid_len = run_length + 2'd1;
        end
      end else begin
        // flush a short run ended by another character
        if (run_length == RunOne || run_length == RunTwo) begin
          a_cnt  = run_length;
          mid_we = 1'b1;
        end
        if (dec) begin
          mid_len  = RunOne;
          mid_char = ch;
        end else begin
          mid_len = RunNone;
          b_put   = 1'b1;
          mid_we  = 1'b1;
        end
      end
    end

    close = sp || end_of_text;
    c_cnt = 2'd0;
    d_put = 1'b0;
    run_length_next   = mid_len;
    run_char_next     = mid_char;
    word_emitted_next = mid_we;
    if (close) begin
      // at word end a lone decorator survives only behind emitted text
      if (mid_len == RunTwo || (mid_len == RunOne && mid_we)) begin
        c_cnt = mid_len;
      end
      d_put             = mid_we || (c_cnt != 2'd0);
      run_length_next   = RunNone;
      run_char_next     = '0;
      word_emitted_next = 1'b0;
    end
  end

  // Lay the four result groups out in order
  always_comb begin
    ab  = {1'b0, a_cnt} + {2'b00, b_put};
    abc = ab + {1'b0, c_cnt};
    burst.cnt = abc + {2'b00, d_put};
    for (int i = 0; i < MaxResult; i++) begin
      if (3'(i) < {1'b0, a_cnt}) begin
        burst.kind[i] = KindChar;
        burst.chr[i]  = run_char;
      end else if (3'(i) < ab) begin
        burst.kind[i] = KindChar;
        burst.chr[i]  = ch;
      end else if (3'(i) < abc) begin
        burst.kind[i] = KindChar;
        burst.chr[i]  = mid_char;
      end else begin
        burst.kind[i] = KindWordEnd;
        burst.chr[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_char     <= '0;
      run_length   <= RunNone;
      word_emitted <= 1'b0;
    end else if (accept) begin
      run_char     <= run_char_next;
      run_length   <= run_length_next;
      word_emitted <= word_emitted_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/wtdf_burst_out.sv */
// ----------------------------------------------------------------------------
// wtdf_burst_out
// Result register: holds the results of one character and hands them out
// one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module wtdf_burst_out import wtdf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire burst_t           burst_in,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  kind,
  output logic [CharW-1:0]      out_char,
  output logic                  last
);

  burst_t          held;
  logic            busy;
  logic [IdxW-1:0] idx;
  logic            xfer;

  assign out_valid = busy;
  assign kind      = held.kind[idx];
  assign out_char  = held.chr[idx];
  assign last      = (CntW'(idx) + CntW'(1)) == held.cnt;
  assign xfer      = busy && out_ready;
  assign free      = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load && burst_in.cnt != '0) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      if (last) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && burst_in.cnt != '0) begin
      held <= burst_in;
    end
  end

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> held.cnt != '0)
    else $error("busy with empty result list");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> CntW'(idx) < held.cnt)
    else $error("result index past result count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_ready) |=> (busy && $stable(idx)))
    else $error("result moved while stalled");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("load while previous results pending");

endmodule

`default_nettype wire

/* rtl/word_tokenizer_decorator_filter.sv */
// ----------------------------------------------------------------------------
// word_tokenizer_decorator_filter
// Splits a UTF-16 character stream into words and filters decorator runs.
// ----------------------------------------------------------------------------
// Output: the first result of a character is offered in the cycle after its
//   transfer; a character causes zero to four results.
// Throughput: with out_ready high, one character per cycle while each causes
//   at most one result; otherwise one result per cycle, set by the output port.
// Reset: synchronous rst clears the run and word state and empties the
//   result register; the block takes input in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module word_tokenizer_decorator_filter import wtdf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  // character input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CharW-1:0] ch,
  input  wire logic             end_of_text,
  // result output channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  kind,
  output logic [CharW-1:0]      out_char,
  output logic                  last
);

  burst_t burst;
  logic   accept;
  logic   free;

  // Take a character whenever the result register is empty or hands out its
  // final result in this cycle; a character with no results still advances
  // the word state.
  assign in_ready = free;
  assign accept   = in_valid && in_ready;

  // Decision logic and run/word state; state advances on each input transfer
  wtdf_step u_step (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ch          (ch),
    .end_of_text (end_of_text),
    .burst       (burst)
  );

  // Result register; hold results until each output transfer drains one
  wtdf_burst_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst_in  (burst),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: word tokenizer with decorator filter testbench
// Streams UTF-16 characters into the tokenizer and tracks its word and
// decorator-run state in a local predictor. Every result transfer is checked
// in order against the predicted tokens. Both channels idle in random bursts,
// except in the closing back-to-back phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import wtdf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Whitespace codes
  localparam logic [CharW-1:0] Space       = 16'h0020;
  localparam logic [CharW-1:0] Tab         = 16'h0009;
  localparam logic [CharW-1:0] LineFeed    = 16'h000A;
  localparam logic [CharW-1:0] VertTab     = 16'h000B;
  localparam logic [CharW-1:0] FormFeed    = 16'h000C;
  localparam logic [CharW-1:0] CarriageRet = 16'h000D;

  localparam int QuietLimit  = 500;  // cycles with no transfer on either side
  localparam int DrainCycles = 10;   // settle time once every token arrived
  localparam int MaxReported = 10;

  // One expected token at the result port
  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] chr;
    logic             last;
  } token_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CharW-1:0] ch = '0;
  logic             end_of_text = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             kind;
  logic [CharW-1:0] out_char;
  logic             last;

  // Tokens still owed by the block, oldest first
  token_t token_q[$];

  // Tokenizer state as the predictor sees it
  logic [CharW-1:0] pend_char    = '0;
  logic [1:0]       pend_len     = RunNone;
  logic             word_emitted = 1'b0;

  logic gaps_on    = 1'b1;
  int   err_count  = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;

  word_tokenizer_decorator_filter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_char   (out_char),
    .last       (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic is_white(input logic [CharW-1:0] c);
    return (c == Space) || (c >= Tab && c <= CarriageRet);
  endfunction

  function automatic logic is_deco(input logic [CharW-1:0] c);
    case (c)
      16'h002D, 16'h002B, 16'h005F, 16'h003D, 16'h007C, 16'h007E: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_token(input logic k, input logic [CharW-1:0] c);
    token_t t;
    t.kind = k;
    t.chr  = c;
    t.last = 1'b0;
    token_q = {token_q, t};
  endfunction

  // Release the held decorator run. A run of three or more never comes out;
  // a lone decorator that would be the whole word is dropped too.
  function automatic void flush_pending(input logic at_word_end);
    logic [1:0] len;
    len      = pend_len;
    pend_len = RunNone;
    if (len == RunNone || len == RunLong) return;
    if (at_word_end && len == RunOne && !word_emitted) return;
    for (int i = 0; i < len; i++) add_token(KindChar, pend_char);
    word_emitted = 1'b1;
  endfunction

  function automatic void close_word();
    flush_pending(1'b1);
    if (word_emitted) add_token(KindWordEnd, '0);
    word_emitted = 1'b0;
    pend_len     = RunNone;
    pend_char    = '0;
  endfunction

  // Append the tokens that one accepted character causes and mark the last
  function automatic void predict_tokens(input logic [CharW-1:0] c, input logic eot);
    int first;
    first = token_q.size();
    if (is_white(c)) begin
      close_word();
    end else begin
      if (pend_len != RunNone && c == pend_char) begin
        if (pend_len != RunLong) pend_len = pend_len + 2'd1;
      end else begin
        flush_pending(1'b0);
        if (is_deco(c)) begin
          pend_char = c;
          pend_len  = RunOne;
        end else begin
          add_token(KindChar, c);
          word_emitted = 1'b1;
        end
      end
      if (eot) close_word();
    end
    if (token_q.size() > first) token_q[token_q.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  function automatic void log_error(input string msg);
    err_count++;
    if (err_count <= MaxReported) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // Compare every result transfer with the oldest owed token
  always @(posedge clk) begin : check_results
    token_t want;
    if (!rst && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        log_error($sformatf("unexpected result kind=%0d char=%h last=%0d",
                            kind, out_char, last));
      end else begin
        want = token_q.pop_front();
        if (kind !== want.kind || out_char !== want.chr || last !== want.last)
          log_error($sformatf(
            "expected kind=%0d char=%h last=%0d, got kind=%0d char=%h last=%0d",
            want.kind, want.chr, want.last, kind, out_char, last));
      end
    end
  end

  // Stall the result side in random bursts while gaps are on
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Count cycles in which neither channel makes a transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("ERROR: no transfer for %0d cycles", QuietLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Offer one character and hold it until the transfer; valid stays high on
  // return so the next character can follow in the very next cycle.
  task automatic send_char(input logic [CharW-1:0] c, input logic eot);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    ch          <= c;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(c, eot);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]}, 1'b0);
  endtask

  function automatic logic [CharW-1:0] pick_white();
    case ($urandom_range(0, 5))
      0:       return Space;
      1:       return Tab;
      2:       return LineFeed;
      3:       return VertTab;
      4:       return FormFeed;
      default: return CarriageRet;
    endcase
  endfunction

  function automatic logic [CharW-1:0] pick_deco();
    case ($urandom_range(0, 5))
      0:       return 16'h002D;
      1:       return 16'h002B;
      2:       return 16'h005F;
      3:       return 16'h003D;
      4:       return 16'h007C;
      default: return 16'h007E;
    endcase
  endfunction

  function automatic logic [CharW-1:0] pick_letter();
    return 16'h0061 + 16'($urandom_range(0, 25));
  endfunction

  // Mostly well-formed words of letters, arbitrary code units and decorator
  // runs, closed by whitespace or end of text; a tenth is raw noise.
  task automatic send_word_stream(input int n_items);
    int               sent;
    int               segs;
    int               pick;
    int               run;
    logic [CharW-1:0] c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(16'($urandom), $urandom_range(0, 7) == 0);
        sent++;
      end else begin
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            send_char(pick_letter(), 1'b0);
            sent++;
          end else if (pick == 4) begin
            send_char(16'($urandom), 1'b0);
            sent++;
          end else begin
            // favor short runs, which the filter may keep
            c   = pick_deco();
            run = (pick < 8) ? $urandom_range(1, 2) : $urandom_range(3, 5);
            repeat (run) begin
              send_char(c, 1'b0);
              sent++;
            end
          end
        end
        case ($urandom_range(0, 11))
          0:       send_char(pick_letter(), 1'b1);
          1:       send_char(pick_deco(), 1'b1);
          2:       send_char(pick_white(), 1'b1);
          default: begin
            repeat ($urandom_range(1, 2)) begin
              send_char(pick_white(), 1'b0);
              sent++;
            end
            sent--;
          end
        endcase
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    // extremes of the code unit inside one word
    send_str("a");
    send_char(16'hFFFF, 1'b0);
    send_char(16'h0000, 1'b0);
    send_char(Space, 1'b0);
    // lone decorator as the whole word: no token, no marker
    send_str("-");
    send_char(Tab, 1'b0);
    // lone decorator after a kept character survives
    send_str("x-");
    send_char(LineFeed, 1'b0);
    // pair of decorators on its own is kept
    send_str("==");
    send_char(CarriageRet, 1'b0);
    // long run saturates and is dropped
    send_str("~~~~b");
    send_char(VertTab, 1'b0);
    // run ended by another decorator, then a dropped run at word end
    send_str("|___");
    send_char(FormFeed, 1'b0);
    // held pair released by a plain character that also ends the text
    send_str("++");
    send_char(16'h006B, 1'b1);
    // whitespace that ends the text closes the word only once
    send_str("z");
    send_char(Space, 1'b1);
    send_char(16'h002D, 1'b1);
    // codes just outside the whitespace range are plain characters
    send_char(16'h0008, 1'b0);
    send_char(16'h000E, 1'b0);
    send_char(16'h001F, 1'b0);
    send_char(16'h0021, 1'b0);
    send_char(Space, 1'b0);
  endtask

  task automatic test_random_text();
    send_word_stream(300);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    send_word_stream(40);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_text();
    test_back_to_back();

    // Drop valid and wait for every owed token, then let the block settle
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
